// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the median filter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define MFW_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define MFW_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `MFW_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

// ===== sv/mfw_pkg.sv =====
// ----------------------------------------------------------------------------
// Median filter package
// Fixed widths, register codes and shared types of the median filter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfw_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int WS_W      = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [WS_W-1:0]  RST_WINDOW_SIZE  = 3'd3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int FIFO_CW    = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_WINDOW_SIZE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic last;
  } med_ctl_t;

endpackage

// ===== sv/mfw_if.sv =====
// ----------------------------------------------------------------------------
// Median filter channels
// Valid/ready channels for pixel beats in and median beats out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfw_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [mfw_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output cmd, output pixel, input ready);
  modport sink (input valid, input cmd, input pixel, output ready);
endinterface

interface mfw_out_if;
  logic                     valid;
  logic                     ready;
  logic [mfw_pkg::PIX_W-1:0] median;
  logic                     last_of_frame;

  modport source (output valid, output median, output last_of_frame, input ready);
  modport sink (input valid, input median, input last_of_frame, output ready);
endinterface

// ===== sv/mfw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mfw_median.sv =====
// ----------------------------------------------------------------------------
// Median select pipeline
// Radix select of the ranked sample, one bit per stage from the MSB down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfw_median #(
  parameter int N  = 49,
  parameter int KW = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mfw_pkg::med_ctl_t                   ctl_i,
  input  logic [N-1:0][mfw_pkg::PIX_W-1:0]    vals_i,
  input  logic [N-1:0]                        cand_i,
  input  logic [KW-1:0]                       rank_i,
  output mfw_pkg::med_ctl_t                   ctl_o,
  output logic [mfw_pkg::PIX_W-1:0]           median_o
);

  localparam int NS = mfw_pkg::PIX_W;

  logic [N-1:0][mfw_pkg::PIX_W-1:0] v_q    [NS+1];
  logic [N-1:0]                     cand_q [NS+1];
  logic [KW-1:0]                    k_q    [NS+1];
  logic [mfw_pkg::PIX_W-1:0]        res_q  [NS+1];
  logic                             last_q [NS+1];
  logic [NS:0]                      vld_q;
  logic [N-1:0]                     zb     [NS];
  logic [KW-1:0]                    cnt0   [NS];
  logic [NS-1:0]                    take_one;

  // candidates whose current bit is zero, and how many there are
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int i = 0; i < N; i++) begin
        zb[s][i] = cand_q[s][i] & ~v_q[s][i][NS-1-s];
      end
      cnt0[s]     = KW'($countones(zb[s]));
      take_one[s] = !(k_q[s] < cnt0[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-1:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    v_q[0]    <= vals_i;
    cand_q[0] <= cand_i;
    k_q[0]    <= rank_i;
    res_q[0]  <= '0;
    last_q[0] <= ctl_i.last;
    for (int s = 0; s < NS; s++) begin
      v_q[s+1]    <= v_q[s];
      last_q[s+1] <= last_q[s];
      res_q[s+1]  <= res_q[s] | (mfw_pkg::PIX_W'(take_one[s]) << (NS-1-s));
      if (!take_one[s]) begin
        cand_q[s+1] <= zb[s];
        k_q[s+1]    <= k_q[s];
      end else begin
        cand_q[s+1] <= cand_q[s] & ~zb[s];
        k_q[s+1]    <= k_q[s] - cnt0[s];
      end
    end
  end

  assign ctl_o.valid = vld_q[NS];
  assign ctl_o.last  = last_q[NS];
  assign median_o    = res_q[NS];

endmodule

// ===== sv/median_filter_window_core.sv =====
// ----------------------------------------------------------------------------
// Median filter window core
// Streaming 2-D median over raster pixels with zero padding at the borders.
// ----------------------------------------------------------------------------
// Pixel beats (cmd pixel) enter on in_i in raster order; each result beat on
// out_o carries the median of the square window around the next output
// position, last_of_frame marking the final result of the frame. A result
// leaves for the pixel that completes its window (half rows and half pixels
// later); after the last pixel, each flush beat pushes out one more result.
// Sizes are latched when the first pixel of a frame is accepted.
// Throughput: one beat per cycle while in_i is ready. The column line store is
// one RAM of MAX_WIDTH entries, read and written back once per beat, with
// forwarding when consecutive beats hit the same column. The path from an
// accepted beat to its result runs through the line store read, the window
// stage, the nine-stage median select pipeline and the output FIFO.
// Reset clears counters and the FIFO; sizes return to 640 x 480, window 3.
// The line store needs no clearing: unwritten rows are masked to zero.
// When out_o stalls, results collect in a 16-beat FIFO; in_i stays ready
// while fewer than 16 results are owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module median_filter_window_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mfw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mfw_pkg::CFG_W-1:0]       cfg_data_i,
  mfw_in_if.sink                          in_i,
  mfw_out_if.source                       out_o
);

  localparam int MAX_HALF = (MAX_WINDOW - 1) / 2;
  localparam int SPAN     = 2 * MAX_HALF + 1;
  localparam int NV       = SPAN - 1;
  localparam int NWIN     = SPAN * SPAN;
  localparam int KW       = $clog2(NWIN + 1);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RW       = $clog2(MAX_HEIGHT);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int HHW      = $clog2(MAX_HEIGHT + 1);
  localparam int IRW      = $clog2(MAX_HEIGHT + MAX_HALF + 2);
  localparam int HW       = $clog2(MAX_HALF + 1);
  localparam int DW       = $clog2(MAX_HALF * MAX_WIDTH + MAX_HALF + 2);
  localparam int MAXD     = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int PW       = ($clog2(MAXD) + 2 > mfw_pkg::CFG_W + 1) ?
                            $clog2(MAXD) + 2 : mfw_pkg::CFG_W + 1;
  localparam int PXW      = mfw_pkg::PIX_W;

  // configuration registers
  logic [mfw_pkg::CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [mfw_pkg::WS_W-1:0]  cfg_ws_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= mfw_pkg::RST_FRAME_WIDTH;
      cfg_h_q  <= mfw_pkg::RST_FRAME_HEIGHT;
      cfg_ws_q <= mfw_pkg::RST_WINDOW_SIZE;
    end else if (cfg_we_i) begin
      unique case (mfw_pkg::cfg_idx_e'(cfg_idx_i))
        mfw_pkg::CFG_FRAME_WIDTH:  cfg_w_q  <= cfg_data_i;
        mfw_pkg::CFG_FRAME_HEIGHT: cfg_h_q  <= cfg_data_i;
        mfw_pkg::CFG_WINDOW_SIZE:  cfg_ws_q <= cfg_data_i[mfw_pkg::WS_W-1:0];
        default: ;
      endcase
    end
  end

  // latched frame sizes and position counters
  logic [WW-1:0]  cur_w_q, w_cl, w_e;
  logic [HHW-1:0] cur_h_q, h_cl, h_e;
  logic [HW-1:0]  cur_hf_q, hf_cl, hf_e;
  logic [DW-1:0]  lat_e;
  logic [mfw_pkg::WS_W-1:0] hraw;

  logic [IRW-1:0] in_row_q, in_row_d;
  logic [CW-1:0]  in_col_q, in_col_d;
  logic [RW-1:0]  out_row_q, out_row_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic [DW-1:0]  d_q, d_d;

  logic idle, start, drain, acc, step, emit, last, pop;

  always_comb begin
    if (cfg_w_q == '0) begin
      w_cl = WW'(1);
    end else if (PW'(cfg_w_q) > PW'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_cl = HHW'(1);
    end else if (PW'(cfg_h_q) > PW'(MAX_HEIGHT)) begin
      h_cl = HHW'(MAX_HEIGHT);
    end else begin
      h_cl = HHW'(cfg_h_q);
    end
    hraw = (cfg_ws_q == '0) ? '0 : ((cfg_ws_q - 1'b1) >> 1);
    if (32'(hraw) > MAX_HALF) begin
      hf_cl = HW'(MAX_HALF);
    end else begin
      hf_cl = HW'(hraw);
    end
  end

  assign idle  = (in_row_q == '0) && (in_col_q == '0) && (out_row_q == '0) &&
                 (out_col_q == '0);
  assign acc   = in_i.valid && in_i.ready;
  assign start = idle && (in_i.cmd == mfw_pkg::CMD_PIXEL);
  assign w_e   = start ? w_cl : cur_w_q;
  assign h_e   = start ? h_cl : cur_h_q;
  assign hf_e  = start ? hf_cl : cur_hf_q;
  assign lat_e = DW'(hf_e) * DW'(w_e) + DW'(hf_e);
  assign drain = PW'(in_row_q) >= PW'(h_e);
  assign step  = acc && (drain || (in_i.cmd == mfw_pkg::CMD_PIXEL));
  assign emit  = acc && (drain || ((in_i.cmd == mfw_pkg::CMD_PIXEL) &&
                 ((DW+1)'(d_q) + (DW+1)'(1) > (DW+1)'(lat_e))));
  assign last  = (PW'(out_row_q) + PW'(1) == PW'(h_e)) &&
                 (PW'(out_col_q) + PW'(1) == PW'(w_e));

  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    d_d       = d_q;
    if (step) begin
      if (WW'(in_col_q) + WW'(1) == w_e) begin
        in_col_d = '0;
        in_row_d = in_row_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
    end
    if (acc && !drain && (in_i.cmd == mfw_pkg::CMD_PIXEL)) begin
      d_d = emit ? d_q : d_q + 1'b1;
    end
    if (emit) begin
      if (last) begin
        // frame done: back to idle
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
        d_d       = '0;
      end else if (WW'(out_col_q) + WW'(1) == w_e) begin
        out_col_d = '0;
        out_row_d = out_row_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      d_q       <= '0;
      cur_w_q   <= WW'(mfw_pkg::RST_FRAME_WIDTH);
      cur_h_q   <= HHW'(mfw_pkg::RST_FRAME_HEIGHT);
      cur_hf_q  <= HW'(1);
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      d_q       <= d_d;
      if (acc && start) begin
        cur_w_q  <= w_cl;
        cur_h_q  <= h_cl;
        cur_hf_q <= hf_cl;
      end
    end
  end

  // border masks of the output window
  logic [SPAN-1:0] rowok_d, colok_d, inwin_d;
  logic [PW-1:0]   base_r, base_c;
  logic [7:0]      sq;
  logic [3:0]      sp;
  logic [KW-1:0]   rank_d;

  always_comb begin
    base_r = PW'(out_row_q) + PW'(hf_e);
    base_c = PW'(out_col_q) + PW'(hf_e);
    for (int k = 0; k < SPAN; k++) begin
      rowok_d[k] = (base_r >= PW'(k)) && ((base_r - PW'(k)) < PW'(h_e));
      colok_d[k] = (base_c >= PW'(k)) && ((base_c - PW'(k)) < PW'(w_e));
      inwin_d[k] = PW'(k) <= (PW'(hf_e) << 1);
    end
    sp     = (4'(hf_e) << 1) + 4'd1;
    sq     = 8'(sp) * 8'(sp);
    rank_d = KW'(sq >> 1);
  end

  // stage B: line store read data, write back, window shift
  logic                 b_step_q, b_emit_q, b_fwd_q, b_last_q;
  logic [PXW-1:0]       b_pix_q;
  logic [CW-1:0]        b_addr_q;
  logic [NV-1:0][PXW-1:0] b_fwd_data_q, rdata, vec_old, b_wdata;
  logic [SPAN-1:0][PXW-1:0] colvec;
  logic [SPAN-1:0]      b_rowok_q, b_colok_q, b_inwin_q;
  logic [KW-1:0]        b_rank_q;

  assign vec_old = b_fwd_q ? b_fwd_data_q : rdata;
  assign colvec  = {vec_old, b_pix_q};
  assign b_wdata = colvec[NV-1:0];

  mfw_ram #(
    .WIDTH (NV * PXW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (b_step_q),
    .waddr_i (b_addr_q),
    .wdata_i (b_wdata),
    .re_i    (step),
    .raddr_i (in_col_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_step_q <= 1'b0;
      b_emit_q <= 1'b0;
      b_fwd_q  <= 1'b0;
    end else begin
      b_step_q <= step;
      b_emit_q <= emit;
      // hold the column being written back when the next beat reads it
      b_fwd_q  <= step && b_step_q && (b_addr_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    b_pix_q      <= in_i.pixel;
    b_addr_q     <= in_col_q;
    b_fwd_data_q <= b_wdata;
    b_last_q     <= last;
    b_rowok_q    <= rowok_d;
    b_colok_q    <= colok_d;
    b_inwin_q    <= inwin_d;
    b_rank_q     <= rank_d;
  end

  logic [SPAN-1:0][SPAN-1:0][PXW-1:0] win_q;

  always_ff @(posedge clk_i) begin
    if (b_step_q) begin
      win_q <= {win_q[SPAN-2:0], colvec};
    end
  end

  // stage C: masked window into the median pipeline
  logic                 c_emit_q, c_last_q;
  logic [SPAN-1:0]      c_rowok_q, c_colok_q, c_inwin_q;
  logic [KW-1:0]        c_rank_q;
  logic [NWIN-1:0][PXW-1:0] vals;
  logic [NWIN-1:0]      cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_emit_q <= 1'b0;
    end else begin
      c_emit_q <= b_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_last_q  <= b_last_q;
    c_rowok_q <= b_rowok_q;
    c_colok_q <= b_colok_q;
    c_inwin_q <= b_inwin_q;
    c_rank_q  <= b_rank_q;
  end

  always_comb begin
    for (int dc = 0; dc < SPAN; dc++) begin
      for (int dr = 0; dr < SPAN; dr++) begin
        vals[dc*SPAN+dr] = (c_rowok_q[dr] && c_colok_q[dc]) ? win_q[dc][dr] : '0;
        cand[dc*SPAN+dr] = c_inwin_q[dr] && c_inwin_q[dc];
      end
    end
  end

  mfw_pkg::med_ctl_t med_ctl_in, med_ctl_out;
  logic [PXW-1:0]    med_val;

  assign med_ctl_in.valid = c_emit_q;
  assign med_ctl_in.last  = c_last_q;

  mfw_median #(
    .N  (NWIN),
    .KW (KW)
  ) u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (med_ctl_in),
    .vals_i   (vals),
    .cand_i   (cand),
    .rank_i   (c_rank_q),
    .ctl_o    (med_ctl_out),
    .median_o (med_val)
  );

  // output FIFO and credit count
  logic [PXW:0]                 fifo_q [mfw_pkg::FIFO_DEPTH];
  logic [mfw_pkg::FIFO_AW-1:0]  wptr_q, rptr_q;
  logic [mfw_pkg::FIFO_CW-1:0]  fifo_cnt_q, credit_q;
  logic                         push;

  assign push = med_ctl_out.valid;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= {med_ctl_out.last, med_val};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      fifo_cnt_q <= '0;
      credit_q   <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      fifo_cnt_q <= fifo_cnt_q + mfw_pkg::FIFO_CW'(push) - mfw_pkg::FIFO_CW'(pop);
      credit_q   <= credit_q + mfw_pkg::FIFO_CW'(acc && emit) - mfw_pkg::FIFO_CW'(pop);
    end
  end

  assign in_i.ready          = credit_q < mfw_pkg::FIFO_CW'(mfw_pkg::FIFO_DEPTH);
  assign out_o.valid         = fifo_cnt_q != '0;
  assign out_o.median        = fifo_q[rptr_q][PXW-1:0];
  assign out_o.last_of_frame = fifo_q[rptr_q][PXW];

  `MFW_ASSERT(a_credit_bound, clk_i, rst_ni, credit_q <= mfw_pkg::FIFO_CW'(mfw_pkg::FIFO_DEPTH), "credit count above FIFO depth")
  `MFW_ASSERT(a_fifo_le_credit, clk_i, rst_ni, fifo_cnt_q <= credit_q, "FIFO holds more beats than owed")
  `MFW_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && (fifo_cnt_q == mfw_pkg::FIFO_CW'(mfw_pkg::FIFO_DEPTH)), "push into full FIFO")
  `MFW_ASSERT(a_fwd_src, clk_i, rst_ni, b_fwd_q |-> $past(b_step_q), "forward without a write back")

endmodule
